/* rtl/core/linear_scan_interval_colorer_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef LINEAR_SCAN_INTERVAL_COLORER_TOP_MACROS_SVH
`define LINEAR_SCAN_INTERVAL_COLORER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define LSIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsic check failed");

// Next-cycle implication, held off while reset is asserted.
`define LSIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsic check failed");

`endif

/* rtl/core/lsic_pkg.sv */
package lsic_pkg;

    localparam int MAX_COLORS = 16;
    localparam int SLOT_W     = $clog2(MAX_COLORS);
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int POS_W      = 24;
    localparam int IDX_W      = 16;
    localparam int COLOR_W    = 4;
    localparam int CFG_W      = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef struct packed {
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
        logic             first_of_set;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   seg_index;
        logic               assigned;
        logic [COLOR_W-1:0] color;
        logic               evict_valid;
        logic [IDX_W-1:0]   evict_index;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PICK  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic pick;
        logic write;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/core/lsic_ctrl.sv */
module lsic_ctrl
    import lsic_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_WRITE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_SCAN : S_IDLE;
            S_SCAN:  n_state = S_PICK;
            S_PICK:  n_state = i_stat.out_free ? S_WRITE : S_PICK;
            S_WRITE: n_state = accept ? S_SCAN : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load  = accept;
        o_cmd.scan  = (r_state == S_SCAN);
        o_cmd.pick  = (r_state == S_PICK) && i_stat.out_free;
        o_cmd.write = (r_state == S_WRITE);
    end

endmodule

/* rtl/core/lsic_dpath.sv */
module lsic_dpath
    import lsic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in_word         i_in_word,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_word        o_out_word,
    output t_stat            o_stat
);

    // active list, one lane per slot
    logic [POS_W-1:0]      r_end [MAX_COLORS];
    logic [IDX_W-1:0]      r_idx [MAX_COLORS];
    logic [COLOR_W-1:0]    r_col [MAX_COLORS];
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_counter;
    logic [CFG_W-1:0]      r_cfg;

    // current word
    logic [POS_W-1:0]      r_start;
    logic [POS_W-1:0]      r_new_end;
    logic [IDX_W-1:0]      r_seg;

    // scan results
    logic [MAX_COLORS-1:0] r_keep;
    logic [MAX_COLORS-1:0] r_gtn;
    logic [MAX_COLORS-1:0] r_beat [MAX_COLORS];

    // pick results
    logic [MAX_COLORS-1:0] r_final;
    logic                  r_append;
    logic [COLOR_W-1:0]    r_app_col;

    logic                  r_out_valid;
    t_out_word             r_out;

    logic [CFG_W-1:0]      ncol;
    logic                  nc_zero;
    logic [IDX_W-1:0]      seg_now;

    logic [MAX_COLORS-1:0] n_keep;
    logic [MAX_COLORS-1:0] n_gtn;
    logic [MAX_COLORS-1:0] n_beat [MAX_COLORS];

    logic [MAX_COLORS-1:0] used;
    logic [MAX_COLORS-1:0] cand;
    logic [MAX_COLORS-1:0] vic;
    logic                  have_free;
    logic [COLOR_W-1:0]    free_col;
    logic                  found;
    logic [COLOR_W-1:0]    vic_col;
    logic [IDX_W-1:0]      vic_idx;
    logic                  have;
    logic                  evict;
    logic [COLOR_W-1:0]    pick_col;

    logic [CNT_W-1:0]      pos [MAX_COLORS];
    logic [CNT_W-1:0]      kept_cnt;
    logic                  do_app;
    logic [POS_W-1:0]      n_end [MAX_COLORS];
    logic [IDX_W-1:0]      n_idx [MAX_COLORS];
    logic [COLOR_W-1:0]    n_col [MAX_COLORS];
    logic [CNT_W-1:0]      n_count;

    function automatic logic [MAX_COLORS-1:0] low_mask(input int j);
        logic [MAX_COLORS-1:0] m;
        m = '0;
        for (int k = 0; k < MAX_COLORS; k++) begin
            m[k] = (k < j);
        end
        return m;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign ncol    = (r_cfg > CFG_W'(MAX_COLORS)) ? CFG_W'(MAX_COLORS) : r_cfg;
    assign nc_zero = (ncol == '0);
    assign seg_now = i_in_word.first_of_set ? '0 : r_counter;

    // scan: expiry, ends beyond the new end, pairwise ranking
    always_comb begin
        for (int j = 0; j < MAX_COLORS; j++) begin
            n_keep[j] = (CNT_W'(j) < r_count) && (nc_zero || (r_end[j] >= r_start));
            n_gtn[j]  = (r_end[j] > r_new_end);
            for (int k = 0; k < MAX_COLORS; k++) begin
                if (k < j) begin
                    n_beat[j][k] = (r_end[j] > r_end[k]);
                end else begin
                    n_beat[j][k] = (r_end[j] >= r_end[k]);
                end
            end
        end
    end

    // pick: lowest free colour, else farthest-ending victim
    always_comb begin
        used = '0;
        for (int j = 0; j < MAX_COLORS; j++) begin
            for (int c = 0; c < MAX_COLORS; c++) begin
                if (r_keep[j] && (r_col[j] == COLOR_W'(c)) && (CFG_W'(c) < ncol)) begin
                    used[c] = 1'b1;
                end
            end
        end
        have_free = 1'b0;
        free_col  = '0;
        for (int c = MAX_COLORS - 1; c >= 0; c--) begin
            if (!used[c] && (CFG_W'(c) < ncol)) begin
                have_free = 1'b1;
                free_col  = COLOR_W'(c);
            end
        end
        cand = nc_zero ? '0 : (r_keep & r_gtn);
        for (int j = 0; j < MAX_COLORS; j++) begin
            vic[j] = cand[j];
            for (int k = 0; k < MAX_COLORS; k++) begin
                if ((k != j) && cand[k] && !r_beat[j][k]) begin
                    vic[j] = 1'b0;
                end
            end
        end
        found   = |vic;
        vic_col = '0;
        vic_idx = '0;
        for (int j = 0; j < MAX_COLORS; j++) begin
            if (vic[j]) begin
                vic_col = vic_col | r_col[j];
                vic_idx = vic_idx | r_idx[j];
            end
        end
        have     = !nc_zero && (have_free || found);
        evict    = !nc_zero && !have_free && found;
        pick_col = have_free ? free_col : vic_col;
    end

    // write-back: compact survivors in order, append the new segment
    always_comb begin
        for (int j = 0; j < MAX_COLORS; j++) begin
            pos[j] = CNT_W'($countones(r_final & low_mask(j)));
        end
        kept_cnt = CNT_W'($countones(r_final));
        do_app   = r_append && (kept_cnt < CNT_W'(MAX_COLORS));
        for (int i = 0; i < MAX_COLORS; i++) begin
            n_end[i] = r_end[i];
            n_idx[i] = r_idx[i];
            n_col[i] = r_col[i];
            for (int j = 0; j < MAX_COLORS; j++) begin
                if (r_final[j] && (pos[j] == CNT_W'(i))) begin
                    n_end[i] = r_end[j];
                    n_idx[i] = r_idx[j];
                    n_col[i] = r_col[j];
                end
            end
            if (do_app && (kept_cnt == CNT_W'(i))) begin
                n_end[i] = r_new_end;
                n_idx[i] = r_seg;
                n_col[i] = r_app_col;
            end
        end
        n_count = kept_cnt + CNT_W'(do_app);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_counter   <= '0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.write) begin
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_counter <= seg_now + IDX_W'(1);
                if (i_in_word.first_of_set) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.pick) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start   <= i_in_word.seg_start;
            r_new_end <= i_in_word.seg_end;
            r_seg     <= seg_now;
        end
        if (i_cmd.scan) begin
            r_keep <= n_keep;
            r_gtn  <= n_gtn;
            for (int j = 0; j < MAX_COLORS; j++) begin
                r_beat[j] <= n_beat[j];
            end
        end
        if (i_cmd.pick) begin
            r_final   <= r_keep & ~(evict ? vic : '0);
            r_append  <= have;
            r_app_col <= pick_col;
            r_out.seg_index   <= r_seg;
            r_out.assigned    <= have;
            r_out.color       <= have ? pick_col : '0;
            r_out.evict_valid <= evict;
            r_out.evict_index <= evict ? vic_idx : '0;
        end
        if (i_cmd.write) begin
            for (int i = 0; i < MAX_COLORS; i++) begin
                r_end[i] <= n_end[i];
                r_idx[i] <= n_idx[i];
                r_col[i] <= n_col[i];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

/* rtl/core/linear_scan_interval_colorer_top.sv */
// Channel  Direction  Handshake                Word
// in       sink       i_in_valid / o_in_ready   t_in_word  (seg_start, seg_end, first_of_set)
// out      source     o_out_valid / i_out_ready t_out_word (seg_index .. evict_index)
// cfg      sink       i_cfg_valid / o_cfg_ready colors_in_use, 5 bits, always ready
//
// Steps per word: accept, scan (expiry and ranking of all
//   16 slots in parallel), pick (free colour or victim), write-back (compaction),
//   with the next word accepted in the write-back cycle.
// Reset: synchronous, active low; empties the list, zeroes the index counter and
//   loads colors_in_use with 8. No clearing pass.
// Stalls: pick waits while the output register holds an untaken word.
module linear_scan_interval_colorer_top
    import lsic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequence each word through scan, pick and write-back
    lsic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // hold the active list, rank it and compact it
    lsic_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_stat      (stat)
    );

endmodule

/* rtl/core/lsic_checker.sv */
`include "linear_scan_interval_colorer_top_macros.svh"

module lsic_checker
    import lsic_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_word        o_out_word
);

    // hold a stalled result word
    `LSIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))

    // an accepted word blocks the input for the next cycle
    `LSIC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // an eviction always hands its colour on
    `LSIC_ASSERT_NOW(a_evict_assigns, i_clk, i_rst_n, o_out_valid && o_out_word.evict_valid, o_out_word.assigned)

endmodule

bind linear_scan_interval_colorer_top lsic_checker u_lsic_checker (.*);
